[hdl/pidpos_pkg.sv]
package pidpos_pkg;

  // Gain registers are unsigned Q8.24.
  localparam int GAIN_WIDTH         = 32;
  localparam int GAIN_FRACTION_BITS = 24;

  // Controller output is divided by this and clamped to the duty limit.
  localparam int OUTPUT_DIVISOR = 1000;
  localparam int DUTY_LIMIT     = 999;
  localparam int DUTY_WIDTH     = 10;

  // The duty limit at the width of the duty field.
  localparam logic [DUTY_WIDTH-1:0] DUTY_MAX = DUTY_WIDTH'(DUTY_LIMIT);

  // Direction codes on the drive channel.
  localparam logic [1:0] DIR_STOP    = 2'd0;
  localparam logic [1:0] DIR_FORWARD = 2'd1;
  localparam logic [1:0] DIR_REVERSE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_PROPORTIONAL_GAIN = 2'd0;
  localparam logic [1:0] REG_INTEGRAL_GAIN     = 2'd1;
  localparam logic [1:0] REG_DERIVATIVE_GAIN   = 2'd2;

  localparam logic [GAIN_WIDTH-1:0] PROPORTIONAL_GAIN_RESET = 32'd67108864;
  localparam logic [GAIN_WIDTH-1:0] INTEGRAL_GAIN_RESET     = 32'd168;
  localparam logic [GAIN_WIDTH-1:0] DERIVATIVE_GAIN_RESET   = 32'd1678;

  typedef struct packed {
    logic signed [31:0] target_position;
    logic signed [31:0] measured_position;
  } tick_t;

  typedef struct packed {
    logic [DUTY_WIDTH-1:0] duty_magnitude;
    logic [1:0]            direction;
  } drive_t;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0] proportional;
    logic [GAIN_WIDTH-1:0] integral;
    logic [GAIN_WIDTH-1:0] derivative;
  } gains_t;

endpackage

[hdl/pidpos_gain_mult.sv]
module pidpos_gain_mult #(
  parameter int POSITION_WIDTH    = 32,
  parameter int ACCUMULATOR_WIDTH = 48
) (
  input  logic                      clk,
  input  logic                      load,
  input  pidpos_pkg::gains_t        gains,
  input  logic signed [POSITION_WIDTH:0]   err,
  input  logic signed [POSITION_WIDTH+1:0] dlt,
  input  logic signed [ACCUMULATOR_WIDTH-1:0] acc,
  output logic signed [pidpos_pkg::GAIN_WIDTH+POSITION_WIDTH+1:0] p_prop,
  output logic signed [pidpos_pkg::GAIN_WIDTH+POSITION_WIDTH+2:0] p_deriv,
  output logic [pidpos_pkg::GAIN_WIDTH+(ACCUMULATOR_WIDTH+1)/2-1:0] p_int_lo,
  output logic signed
    [pidpos_pkg::GAIN_WIDTH+ACCUMULATOR_WIDTH-(ACCUMULATOR_WIDTH+1)/2:0] p_int_hi
);

  localparam int HW = (ACCUMULATOR_WIDTH + 1) / 2;

  logic signed [pidpos_pkg::GAIN_WIDTH:0] kp;
  logic signed [pidpos_pkg::GAIN_WIDTH:0] ki;
  logic signed [pidpos_pkg::GAIN_WIDTH:0] kd;
  logic signed [ACCUMULATOR_WIDTH-HW-1:0] acc_hi;
  logic [HW-1:0]                          acc_lo;

  // Gains are unsigned, so a zero sign bit turns them into signed operands.
  assign kp = {1'b0, gains.proportional};
  assign ki = {1'b0, gains.integral};
  assign kd = {1'b0, gains.derivative};

  // The accumulator is split into a signed upper half and an unsigned lower
  // half so that each integral product stays near 32 by 24 bits.
  assign acc_hi = acc[ACCUMULATOR_WIDTH-1:HW];
  assign acc_lo = acc[HW-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      p_prop   <= kp * err;
      p_deriv  <= kd * dlt;
      p_int_lo <= gains.integral * acc_lo;
      p_int_hi <= ki * acc_hi;
    end
  end

endmodule

[hdl/pid_position_motor_drive_unit.sv]
// PID position controller with sign-magnitude PWM drive output.
//
// Each item on the tick channel (tick_valid / tick_stall / tick) carries a
// target and a measured encoder position. The block forms the position
// error, adds it into a saturating integral accumulator and drives one item
// on the drive channel (drive_valid / drive_stall / drive): the PWM duty
// magnitude 0..999 and a stop, forward or reverse direction code. The user
// must write the gains through cfg_write / cfg_index / cfg_data only while
// the block is idle (not enforced); a write to an unknown index is ignored.
//
// The datapath is an eight-stage pipeline. An item accepted on tick passes
// through err, acc, prod, part, sum, mag, div and drive stages in order,
// and while drive_stall stays low the sustained rate is one item per cycle.
// Each stage holds one item and moves it on whenever the stage after it is
// empty or moving too. When the receiver holds drive_stall high, the drive
// item stays unchanged and the stages behind it keep filling; tick_stall
// rises only once every stage holds an item.
// Reset clears the pipeline, the integral accumulator and the stored error,
// and loads the default gains.
module pid_position_motor_drive_unit #(
  parameter int POSITION_WIDTH    = 32,
  parameter int ACCUMULATOR_WIDTH = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                tick_valid,
  output logic                tick_stall,
  input  pidpos_pkg::tick_t   tick,
  output logic                drive_valid,
  input  logic                drive_stall,
  output pidpos_pkg::drive_t  drive
);

  localparam int GW  = pidpos_pkg::GAIN_WIDTH;
  localparam int PW  = POSITION_WIDTH;
  localparam int EW  = PW + 1;   // error
  localparam int DW  = PW + 2;   // error difference
  localparam int AW  = ACCUMULATOR_WIDTH;
  localparam int HW  = (AW + 1) / 2;
  localparam int PP_W  = GW + EW + 1;
  localparam int PD_W  = GW + DW + 1;
  localparam int PIL_W = GW + HW;
  localparam int PIH_W = GW + AW - HW + 1;
  // Full controller sum, signed; large enough that no term can overflow it.
  localparam int SW  = GW + ((PW + 2 > AW) ? PW + 2 : AW) + 2;
  localparam int FB  = pidpos_pkg::GAIN_FRACTION_BITS;
  localparam int DUW = pidpos_pkg::DUTY_WIDTH;
  // Scaled magnitudes below this threshold give a duty below the limit.
  localparam int QW  = $clog2(pidpos_pkg::DUTY_LIMIT * pidpos_pkg::OUTPUT_DIVISOR);
  localparam logic [QW-1:0] DUTY_THRESHOLD =
    QW'(pidpos_pkg::DUTY_LIMIT * pidpos_pkg::OUTPUT_DIVISOR);
  localparam logic [QW-1:0] DIVISOR_Q = QW'(pidpos_pkg::OUTPUT_DIVISOR);
  // Reciprocal of the divisor; the estimate is low by at most one.
  localparam int DIV_SHIFT = QW + 10;
  localparam int RW        = DIV_SHIFT - 9;
  localparam logic [63:0] RECIP_FULL = (64'd1 << DIV_SHIFT) / 64'd1000;
  localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];
  localparam logic [DUW-1:0] DUTY_MAX = DUW'(pidpos_pkg::DUTY_LIMIT);
  localparam logic [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

  // Gain registers.
  pidpos_pkg::gains_t gains;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.proportional <= pidpos_pkg::PROPORTIONAL_GAIN_RESET;
      gains.integral     <= pidpos_pkg::INTEGRAL_GAIN_RESET;
      gains.derivative   <= pidpos_pkg::DERIVATIVE_GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pidpos_pkg::REG_PROPORTIONAL_GAIN: gains.proportional <= cfg_data;
        pidpos_pkg::REG_INTEGRAL_GAIN:     gains.integral     <= cfg_data;
        pidpos_pkg::REG_DERIVATIVE_GAIN:   gains.derivative   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage takes a new item when it is empty or
  // when its own item moves on in the same cycle.
  logic err_valid, acc_valid, prod_valid, part_valid, sum_valid;
  logic mag_valid, div_valid;
  logic err_ready, acc_ready, prod_ready, part_ready, sum_ready;
  logic mag_ready, div_ready, drive_ready;

  assign drive_ready = !drive_valid || !drive_stall;
  assign div_ready   = !div_valid   || drive_ready;
  assign mag_ready   = !mag_valid   || div_ready;
  assign sum_ready   = !sum_valid   || mag_ready;
  assign part_ready  = !part_valid  || sum_ready;
  assign prod_ready  = !prod_valid  || part_ready;
  assign acc_ready   = !acc_valid   || prod_ready;
  assign err_ready   = !err_valid   || acc_ready;
  assign tick_stall  = !err_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_valid   <= 1'b0;
      acc_valid   <= 1'b0;
      prod_valid  <= 1'b0;
      part_valid  <= 1'b0;
      sum_valid   <= 1'b0;
      mag_valid   <= 1'b0;
      div_valid   <= 1'b0;
      drive_valid <= 1'b0;
    end else begin
      if (err_ready)   err_valid   <= tick_valid;
      if (acc_ready)   acc_valid   <= err_valid;
      if (prod_ready)  prod_valid  <= acc_valid;
      if (part_ready)  part_valid  <= prod_valid;
      if (sum_ready)   sum_valid   <= part_valid;
      if (mag_ready)   mag_valid   <= sum_valid;
      if (div_ready)   div_valid   <= mag_valid;
      if (drive_ready) drive_valid <= div_valid;
    end
  end

  // Stage 1: position error from the low bits of each position field.
  logic signed [EW-1:0] err;
  logic [EW-1:0] tgt_ext, msr_ext;

  assign tgt_ext = {tick.target_position[PW-1], tick.target_position[PW-1:0]};
  assign msr_ext = {tick.measured_position[PW-1], tick.measured_position[PW-1:0]};

  always_ff @(posedge clk) begin
    if (tick_valid && err_ready) begin
      err <= tgt_ext - msr_ext;
    end
  end

  // Stage 2: the accumulator and the previous error are the controller
  // state and also the payload of this stage. They update only when an item
  // enters, so a stalled item still sees the state it left behind.
  logic signed [AW-1:0] acc;
  logic signed [EW-1:0] last_err;
  logic signed [DW-1:0] dlt;
  logic [AW:0]          acc_sum;
  logic [AW-1:0]        acc_next;

  assign acc_sum = {acc[AW-1], acc} + {{(AW+1-EW){err[EW-1]}}, err};

  // Saturate when the two top bits of the widened sum disagree.
  always_comb begin
    if (acc_sum[AW] != acc_sum[AW-1]) begin
      acc_next = acc_sum[AW] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = acc_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      last_err <= '0;
    end else if (err_valid && acc_ready) begin
      acc      <= acc_next;
      last_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (err_valid && acc_ready) begin
      dlt <= {err[EW-1], err} - {last_err[EW-1], last_err};
    end
  end

  // Stage 3: the gain products. last_err holds the error of the item that
  // sits in stage 2.
  logic signed [PP_W-1:0]  p_prop;
  logic signed [PD_W-1:0]  p_deriv;
  logic [PIL_W-1:0]        p_int_lo;
  logic signed [PIH_W-1:0] p_int_hi;

  pidpos_gain_mult #(
    .POSITION_WIDTH    (POSITION_WIDTH),
    .ACCUMULATOR_WIDTH (ACCUMULATOR_WIDTH)
  ) u_gain_mult (
    .clk      (clk),
    .load     (acc_valid && prod_ready),
    .gains    (gains),
    .err      (last_err),
    .dlt      (dlt),
    .acc      (acc),
    .p_prop   (p_prop),
    .p_deriv  (p_deriv),
    .p_int_lo (p_int_lo),
    .p_int_hi (p_int_hi)
  );

  // Stage 4: partial sums. Stage 5: full controller sum.
  logic [SW-1:0] part_pd, part_i, sum;

  always_ff @(posedge clk) begin
    if (prod_valid && part_ready) begin
      part_pd <= SW'(p_prop) + SW'(p_deriv);
      part_i  <= (SW'(p_int_hi) << HW) + SW'(p_int_lo);
    end
    if (part_valid && sum_ready) begin
      sum <= part_pd + part_i;
    end
  end

  // Stage 6: sign and magnitude, so that the shift and the division below
  // truncate toward zero.
  logic [SW-1:0] mag;
  logic          mag_neg;

  always_ff @(posedge clk) begin
    if (sum_valid && mag_ready) begin
      mag_neg <= sum[SW-1];
      mag     <= sum[SW-1] ? (~sum + SW'(1)) : sum;
    end
  end

  // Stage 7: drop the gain fraction, flag outputs beyond the duty limit and
  // estimate the quotient by the divisor with a reciprocal multiply.
  logic [QW+RW-1:0] est_prod;
  logic             over_limit;
  logic             div_over, div_neg;
  logic [QW-1:0]    div_q;
  logic [DUW-1:0]   div_est;

  assign est_prod   = mag[FB +: QW] * RECIP;
  assign over_limit = (|mag[SW-1:FB+QW]) || (mag[FB +: QW] >= DUTY_THRESHOLD);

  always_ff @(posedge clk) begin
    if (mag_valid && div_ready) begin
      div_over <= over_limit;
      div_neg  <= mag_neg;
      div_q    <= mag[FB +: QW];
      div_est  <= est_prod[DIV_SHIFT +: DUW];
    end
  end

  // Stage 8: correct the estimate by one where the remainder shows it is
  // low, clamp, and pick the direction.
  logic [QW-1:0]  est_scaled, rem;
  logic [DUW-1:0] duty_val;
  logic [1:0]     dir_val;

  assign est_scaled = QW'(div_est) * DIVISOR_Q;
  assign rem        = div_q - est_scaled;

  always_comb begin
    if (div_over) begin
      duty_val = DUTY_MAX;
    end else if (rem >= DIVISOR_Q) begin
      duty_val = div_est + DUW'(1);
    end else begin
      duty_val = div_est;
    end
    if (duty_val == '0) begin
      dir_val = pidpos_pkg::DIR_STOP;
    end else if (div_neg) begin
      dir_val = pidpos_pkg::DIR_REVERSE;
    end else begin
      dir_val = pidpos_pkg::DIR_FORWARD;
    end
  end

  always_ff @(posedge clk) begin
    if (div_valid && drive_ready) begin
      drive.duty_magnitude <= duty_val;
      drive.direction      <= dir_val;
    end
  end

endmodule

[hdl/pidpos_checker.sv]
module pidpos_checker (
  input logic               clk,
  input logic               rst,
  input logic               drive_valid,
  input logic               drive_stall,
  input pidpos_pkg::drive_t drive
);

  // The duty never exceeds the clamp limit.
  assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> drive.duty_magnitude <= pidpos_pkg::DUTY_MAX)
    else $error("duty magnitude above limit");

  // Stop goes with zero duty and only with zero duty.
  assert property (@(posedge clk) disable iff (rst)
    drive_valid |-> ((drive.duty_magnitude == '0) ==
                     (drive.direction == pidpos_pkg::DIR_STOP)))
    else $error("direction does not match duty magnitude");

  // A nonzero duty carries forward or reverse, never the unused code.
  assert property (@(posedge clk) disable iff (rst)
    drive_valid && drive.duty_magnitude != '0 |->
      drive.direction == pidpos_pkg::DIR_FORWARD ||
      drive.direction == pidpos_pkg::DIR_REVERSE)
    else $error("invalid direction code");

  // A stalled drive item stays in place.
  assert property (@(posedge clk) disable iff (rst)
    drive_valid && drive_stall |=> drive_valid && $stable(drive))
    else $error("stalled drive item changed");

  // Reset leaves no item on the drive channel.
  assert property (@(posedge clk) rst |=> !drive_valid)
    else $error("drive item present after reset");

endmodule

bind pid_position_motor_drive_unit pidpos_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .drive_valid (drive_valid),
  .drive_stall (drive_stall),
  .drive       (drive)
);
